// ----- rtl/dsc_pkg.sv -----
// shared types, constants and the control program of the dds command serializer
package dsc_pkg;

    // system clock of the dds chip in hz
    localparam int SYS_CLOCK_HZ = 500000000;
    // width of a frequency below the system clock
    localparam int RemW = $clog2(SYS_CLOCK_HZ + 1);
    // tuning word width and frame geometry
    localparam int TwW      = 32;
    localparam int FrameW   = 40;
    localparam int BitCntW  = 6;
    localparam int DivCntW  = 2;
    localparam int PcW      = 4;

    // reciprocal of the system clock, scaled so it fills the tuning word width
    localparam int RecipSh = $clog2(SYS_CLOCK_HZ) - 1;
    localparam int ProdW   = RemW + TwW;
    localparam logic [TwW-1:0] RECIP_CLK =
        TwW'((64'd1 << (TwW + RecipSh)) / 64'(SYS_CLOCK_HZ));

    // tuning word unit steps
    localparam logic [DivCntW-1:0] DIV_IDLE = 2'd0;
    localparam logic [DivCntW-1:0] DIV_FIX  = 2'd1;
    localparam logic [DivCntW-1:0] DIV_BACK = 2'd2;
    localparam logic [DivCntW-1:0] DIV_EST  = 2'd3;

    // opcodes of a command
    localparam logic [1:0] OPC_FREQ  = 2'd0;
    localparam logic [1:0] OPC_PHASE = 2'd1;
    localparam logic [1:0] OPC_AMP   = 2'd2;
    localparam logic [1:0] OPC_RAW   = 2'd3;

    // register addresses
    localparam logic [7:0] ADDR_CSR   = 8'h00;
    localparam logic [7:0] ADDR_CFTW0 = 8'h04;
    localparam logic [7:0] ADDR_CPOW0 = 8'h05;
    localparam logic [7:0] ADDR_ACR   = 8'h06;

    // micro operations
    localparam logic [2:0] OP_WAIT_IN  = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_SHIFT    = 3'd2;
    localparam logic [2:0] OP_JUMP     = 3'd3;
    localparam logic [2:0] OP_WAIT_DIV = 3'd4;

    // jump conditions
    localparam logic [2:0] C_NEVER  = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_RAW    = 3'd2;
    localparam logic [2:0] C_FREQ   = 3'd3;
    localparam logic [2:0] C_PHASE  = 3'd4;

    // frame sources
    localparam logic [2:0] FS_CSR   = 3'd0;
    localparam logic [2:0] FS_FREQ  = 3'd1;
    localparam logic [2:0] FS_PHASE = 3'd2;
    localparam logic [2:0] FS_AMP   = 3'd3;
    localparam logic [2:0] FS_RAW   = 3'd4;

    // program steps
    localparam logic [PcW-1:0] S_IDLE     = 4'd0;
    localparam logic [PcW-1:0] S_CSR_LD   = 4'd1;
    localparam logic [PcW-1:0] S_CSR_SH   = 4'd2;
    localparam logic [PcW-1:0] S_DISP_F   = 4'd3;
    localparam logic [PcW-1:0] S_DISP_P   = 4'd4;
    localparam logic [PcW-1:0] S_AMP_LD   = 4'd5;
    localparam logic [PcW-1:0] S_AMP_SH   = 4'd6;
    localparam logic [PcW-1:0] S_DIV_WAIT = 4'd7;
    localparam logic [PcW-1:0] S_FREQ_LD  = 4'd8;
    localparam logic [PcW-1:0] S_FREQ_SH  = 4'd9;
    localparam logic [PcW-1:0] S_PH_LD    = 4'd10;
    localparam logic [PcW-1:0] S_PH_SH    = 4'd11;
    localparam logic [PcW-1:0] S_RAW_LD   = 4'd12;
    localparam logic [PcW-1:0] S_RAW_SH   = 4'd13;

    // one control word
    typedef struct packed {
        logic [2:0]     op;
        logic [2:0]     cond;
        logic [PcW-1:0] target;
        logic [2:0]     fsel;
        logic           last;
    } cw_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic       capture;
        logic       load;
        logic       shift;
        logic [2:0] fsel;
        logic       last;
    } ctrl_t;

    // datapath to sequencer status
    typedef struct packed {
        logic emit_end;
    } stat_t;

    // control program rom
    function automatic cw_t cw_rom(input logic [PcW-1:0] pc);
        cw_t cw;
        cw = '{op: OP_WAIT_IN, cond: C_NEVER, target: S_IDLE, fsel: FS_CSR, last: 1'b0};
        case (pc)
            S_IDLE:     cw = '{OP_WAIT_IN,  C_RAW,    S_RAW_LD,   FS_CSR,   1'b0};
            S_CSR_LD:   cw = '{OP_LOAD,     C_NEVER,  S_IDLE,     FS_CSR,   1'b0};
            S_CSR_SH:   cw = '{OP_SHIFT,    C_NEVER,  S_IDLE,     FS_CSR,   1'b0};
            S_DISP_F:   cw = '{OP_JUMP,     C_FREQ,   S_DIV_WAIT, FS_CSR,   1'b0};
            S_DISP_P:   cw = '{OP_JUMP,     C_PHASE,  S_PH_LD,    FS_CSR,   1'b0};
            S_AMP_LD:   cw = '{OP_LOAD,     C_NEVER,  S_IDLE,     FS_AMP,   1'b0};
            S_AMP_SH:   cw = '{OP_SHIFT,    C_ALWAYS, S_IDLE,     FS_AMP,   1'b1};
            S_DIV_WAIT: cw = '{OP_WAIT_DIV, C_NEVER,  S_IDLE,     FS_FREQ,  1'b0};
            S_FREQ_LD:  cw = '{OP_LOAD,     C_NEVER,  S_IDLE,     FS_FREQ,  1'b0};
            S_FREQ_SH:  cw = '{OP_SHIFT,    C_ALWAYS, S_IDLE,     FS_FREQ,  1'b1};
            S_PH_LD:    cw = '{OP_LOAD,     C_NEVER,  S_IDLE,     FS_PHASE, 1'b0};
            S_PH_SH:    cw = '{OP_SHIFT,    C_ALWAYS, S_IDLE,     FS_PHASE, 1'b1};
            S_RAW_LD:   cw = '{OP_LOAD,     C_NEVER,  S_IDLE,     FS_RAW,   1'b0};
            S_RAW_SH:   cw = '{OP_SHIFT,    C_ALWAYS, S_IDLE,     FS_RAW,   1'b1};
            default:    cw = '{OP_JUMP,     C_ALWAYS, S_IDLE,     FS_CSR,   1'b0};
        endcase
        return cw;
    endfunction

endpackage

// ----- rtl/dsc_divider.sv -----
// reciprocal multiplier that forms the frequency tuning word in three steps
module dsc_divider
    import dsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      value,
    output logic             busy,
    output logic [TwW-1:0]   quotient
);

    logic [RemW-1:0]    num_reg, num_next;
    logic [ProdW-1:0]   prod_reg, prod_next;
    logic [TwW-1:0]     q_reg, q_next;
    logic [DivCntW-1:0] step_reg, step_next;
    logic [ProdW-1:0]   rem;
    logic               ge1, ge2;

    // estimate by the scaled reciprocal, which is at most two low,
    // then multiply back and add the whole clocks left in the remainder
    always_comb
    begin
        rem       = {num_reg, TwW'(0)} - prod_reg;
        ge1       = rem >= ProdW'(SYS_CLOCK_HZ);
        ge2       = rem >= (ProdW'(SYS_CLOCK_HZ) << 1);
        num_next  = num_reg;
        prod_next = prod_reg;
        q_next    = q_reg;
        step_next = step_reg;
        if (start)
        begin
            num_next  = value[RemW-1:0];
            step_next = DIV_EST;
        end
        else
        begin
            case (step_reg)
                DIV_EST:
                begin
                    prod_next = ProdW'(num_reg) * ProdW'(RECIP_CLK);
                    step_next = DIV_BACK;
                end
                DIV_BACK:
                begin
                    q_next    = prod_reg[RecipSh +: TwW];
                    prod_next = ProdW'(prod_reg[RecipSh +: TwW]) * ProdW'(SYS_CLOCK_HZ);
                    step_next = DIV_FIX;
                end
                DIV_FIX:
                begin
                    q_next    = q_reg + TwW'({ge2, ge1 && !ge2});
                    step_next = DIV_IDLE;
                end
                default:
                begin
                    step_next = DIV_IDLE;
                end
            endcase
        end
    end

    // step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= DIV_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // operand, product and quotient
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
    end

    assign busy     = step_reg != DIV_IDLE;
    assign quotient = q_reg;

endmodule

// ----- rtl/dsc_datapath.sv -----
// command latch, frame shift register and output register
module dsc_datapath
    import dsc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ctrl_t          ctrl,
    input  logic [1:0]     channel,
    input  logic [31:0]    value,
    input  logic [7:0]     raw_address,
    input  logic [2:0]     raw_byte_count,
    input  logic           raw_update,
    input  logic [TwW-1:0] quotient,
    output stat_t          stat,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           sdio_bit,
    output logic           frame_start,
    output logic           frame_end,
    output logic           io_update,
    output logic           last
);

    logic [1:0]          channel_reg;
    logic [31:0]         value_reg;
    logic [7:0]          raddr_reg;
    logic [2:0]          rcount_reg;
    logic                rupd_reg;
    logic [FrameW-1:0]   sr_reg, sr_next;
    logic [BitCntW-1:0]  cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic                upd_reg, upd_next;
    logic                ov_reg, ov_next;
    logic                sdio_reg, start_reg, end_reg, iou_reg, last_reg;
    logic [7:0]          f_addr;
    logic [31:0]         f_data;
    logic [2:0]          f_bytes;
    logic                f_upd;
    logic [9:0]          amp10;
    logic [TwW-1:0]      tw;
    logic                emit, emit_end;

    // frame contents by source
    always_comb
    begin
        amp10   = (value_reg > 32'd1023) ? 10'h3FF : value_reg[9:0];
        tw      = (value_reg >= 32'(SYS_CLOCK_HZ)) ? '1 : quotient;
        f_addr  = ADDR_CSR;
        f_data  = {24'd0, 8'(8'h10 << channel_reg)};
        f_bytes = 3'd1;
        f_upd   = 1'b1;
        case (ctrl.fsel)
            FS_CSR:
            begin
                f_addr  = ADDR_CSR;
                f_data  = {24'd0, 8'(8'h10 << channel_reg)};
                f_bytes = 3'd1;
            end
            FS_FREQ:
            begin
                f_addr  = ADDR_CFTW0;
                f_data  = tw;
                f_bytes = 3'd4;
            end
            FS_PHASE:
            begin
                f_addr  = ADDR_CPOW0;
                f_data  = {18'd0, value_reg[13:0]};
                f_bytes = 3'd2;
            end
            FS_AMP:
            begin
                f_addr  = ADDR_ACR;
                f_data  = {16'd0, 3'b000, 1'b1, 2'b00, amp10};
                f_bytes = 3'd3;
            end
            FS_RAW:
            begin
                f_addr  = raddr_reg;
                f_data  = value_reg;
                f_bytes = (rcount_reg > 3'd4) ? 3'd4 : rcount_reg;
                f_upd   = rupd_reg;
            end
            default:
            begin
                f_addr  = ADDR_CSR;
                f_bytes = 3'd1;
            end
        endcase
    end

    // load and shift the frame, msb first
    always_comb
    begin
        emit       = ctrl.shift && (!ov_reg || out_ready) && (cnt_reg != '0);
        emit_end   = emit && (cnt_reg == BitCntW'(1));
        sr_next    = sr_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        upd_next   = upd_reg;
        if (ctrl.load)
        begin
            sr_next    = {f_addr, 32'(f_data << (6'd32 - {f_bytes, 3'b000}))};
            cnt_next   = 6'd8 + {f_bytes, 3'b000};
            first_next = 1'b1;
            upd_next   = f_upd;
        end
        else if (emit)
        begin
            sr_next    = {sr_reg[FrameW-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            first_next = 1'b0;
        end
        ov_next = emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            channel_reg <= channel;
            value_reg   <= value;
            raddr_reg   <= raw_address;
            rcount_reg  <= raw_byte_count;
            rupd_reg    <= raw_update;
        end
        sr_reg    <= sr_next;
        first_reg <= first_next;
        upd_reg   <= upd_next;
        if (emit)
        begin
            sdio_reg  <= sr_reg[FrameW-1];
            start_reg <= first_reg;
            end_reg   <= emit_end;
            iou_reg   <= emit_end && upd_reg;
            last_reg  <= emit_end && ctrl.last;
        end
    end

    assign stat.emit_end = emit_end;
    assign out_valid     = ov_reg;
    assign sdio_bit      = sdio_reg;
    assign frame_start   = start_reg;
    assign frame_end     = end_reg;
    assign io_update     = iou_reg;
    assign last          = last_reg;

endmodule

// ----- rtl/dds_spi_command_serializer.sv -----
// top level: microcoded sequencer driving the frame datapath and tuning word divider
//
//   channel   signals                                          direction
//   in        in_valid, in_ready, opcode, channel, value,      command beats in
//             raw_address, raw_byte_count, raw_update
//   out       out_valid, out_ready, sdio_bit, frame_start,     one serial bit per beat
//             frame_end, io_update, last
//
// one command is taken at a time; serial bits go out one per cycle while out_ready stays high.
// a command enters, then each frame has a load step and then its bits, with a step per
// dispatch test in between; the 3-step tuning word unit is done while the channel-select
// frame shifts.
// a stall on out_ready holds the shifter at the current bit.
// rst_n clears the step counter, the divider step, the bit counter and the output valid.
module dds_spi_command_serializer
    import dsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  channel,
    input  logic [31:0] value,
    input  logic [7:0]  raw_address,
    input  logic [2:0]  raw_byte_count,
    input  logic        raw_update,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sdio_bit,
    output logic        frame_start,
    output logic        frame_end,
    output logic        io_update,
    output logic        last
);

    logic [PcW-1:0] pc_reg, pc_next;
    logic [1:0]     opc_reg;
    cw_t            cw;
    ctrl_t          ctrl;
    stat_t          stat;
    logic           accept;
    logic           cond_ok;
    logic [1:0]     opc_sel;
    logic           div_busy;
    logic [TwW-1:0] quotient;

    // control word fetch and condition evaluation
    always_comb
    begin
        cw      = cw_rom(pc_reg);
        accept  = in_valid && (cw.op == OP_WAIT_IN);
        opc_sel = (cw.op == OP_WAIT_IN) ? opcode : opc_reg;
        case (cw.cond)
            C_NEVER:  cond_ok = 1'b0;
            C_ALWAYS: cond_ok = 1'b1;
            C_RAW:    cond_ok = opc_sel == OPC_RAW;
            C_FREQ:   cond_ok = opc_sel == OPC_FREQ;
            C_PHASE:  cond_ok = opc_sel == OPC_PHASE;
            default:  cond_ok = 1'b0;
        endcase
    end

    // step counter
    always_comb
    begin
        pc_next = pc_reg;
        case (cw.op)
            OP_WAIT_IN:
            begin
                if (in_valid)
                begin
                    pc_next = cond_ok ? cw.target : pc_reg + 1'b1;
                end
            end
            OP_LOAD:
            begin
                pc_next = pc_reg + 1'b1;
            end
            OP_SHIFT:
            begin
                if (stat.emit_end)
                begin
                    pc_next = cond_ok ? cw.target : pc_reg + 1'b1;
                end
            end
            OP_JUMP:
            begin
                pc_next = cond_ok ? cw.target : pc_reg + 1'b1;
            end
            OP_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                pc_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // opcode kept for later dispatch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opc_reg <= opcode;
        end
    end

    // datapath controls
    always_comb
    begin
        ctrl.capture = accept;
        ctrl.load    = cw.op == OP_LOAD;
        ctrl.shift   = cw.op == OP_SHIFT;
        ctrl.fsel    = cw.fsel;
        ctrl.last    = cw.last;
    end

    assign in_ready = cw.op == OP_WAIT_IN;

    dsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .value    (value),
        .busy     (div_busy),
        .quotient (quotient)
    );

    dsc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .channel        (channel),
        .value          (value),
        .raw_address    (raw_address),
        .raw_byte_count (raw_byte_count),
        .raw_update     (raw_update),
        .quotient       (quotient),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sdio_bit       (sdio_bit),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .io_update      (io_update),
        .last           (last)
    );

    // a waiting output beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({sdio_bit, frame_start, frame_end, io_update, last}))
        else $error("output beat changed while waiting");

    // update pulse only on a frame's closing bit
    a_upd_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && io_update |-> frame_end)
        else $error("io_update without frame_end");

    // tuning word frame is only loaded once the divider has finished
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_FREQ_LD |-> !div_busy)
        else $error("frequency frame loaded while divider busy");

    // an accepted command starts the divider
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> div_busy)
        else $error("divider not started on command");

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the dds serial command frame generator
module testbench
    import dsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 600000;
    localparam int HoldCycles = 400;

    // one serial bit as seen on the output channel
    typedef struct packed {
        logic sdio;
        logic fstart;
        logic fend;
        logic upd;
        logic lst;
    } serial_bit_t;

    // predicts the serial bits of each command and checks them in order
    class frame_scoreboard;
        serial_bit_t expected_bits[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // append one frame: address byte then nbytes of data, msb first
        function void add_frame(logic [7:0] addr, logic [31:0] data, int nbytes, logic pulse);
            logic [63:0] word;
            int          nbits;
            serial_bit_t b;
            nbits = 8 + 8 * nbytes;
            word  = 64'(addr) << (8 * nbytes);
            if (nbytes >= 4)
                word = word | 64'(data);
            else if (nbytes > 0)
                word = word | (64'(data) & ((64'd1 << (8 * nbytes)) - 64'd1));
            for (int i = 0; i < nbits; i++)
            begin
                b.sdio   = word[nbits - 1 - i];
                b.fstart = (i == 0);
                b.fend   = (i == nbits - 1);
                b.upd    = (i == nbits - 1) && pulse;
                b.lst    = 1'b0;
                expected_bits.push_back(b);
            end
        endfunction

        // accepted command beat: queue every bit it should produce
        function void note_command(logic [1:0] opc, logic [1:0] ch, logic [31:0] val,
                                   logic [7:0] raddr, logic [2:0] rcount, logic rupd);
            logic [63:0] tuning;
            logic [31:0] amp;
            int          nbytes;
            if (opc == OPC_RAW)
            begin
                nbytes = (rcount > 3'd4) ? 4 : int'(rcount);
                add_frame(raddr, val, nbytes, rupd);
            end
            else
            begin
                // channel select frame, one-hot in the upper nibble
                add_frame(ADDR_CSR, 32'(8'h10 << ch), 1, 1'b1);
                case (opc)
                    OPC_FREQ:
                    begin
                        tuning = {val, 32'h0} / 64'(SYS_CLOCK_HZ);
                        if (tuning > 64'hFFFF_FFFF)
                            tuning = 64'hFFFF_FFFF;
                        add_frame(ADDR_CFTW0, tuning[31:0], 4, 1'b1);
                    end
                    OPC_PHASE:
                        add_frame(ADDR_CPOW0, val & 32'h3FFF, 2, 1'b1);
                    default:
                    begin
                        amp = (val > 32'd1023) ? 32'd1023 : val;
                        add_frame(ADDR_ACR, amp | 32'h1000, 3, 1'b1);
                    end
                endcase
            end
            expected_bits[expected_bits.size() - 1].lst = 1'b1;
        endfunction

        // accepted output beat: compare with the oldest expected bit
        function void check_bit(serial_bit_t got);
            serial_bit_t exp_bit;
            if (expected_bits.size() == 0)
            begin
                $error("output beat with nothing expected");
                mismatch_count++;
                return;
            end
            exp_bit = expected_bits.pop_front();
            if (got.sdio !== exp_bit.sdio)
            begin
                $error("sdio_bit: expected %0b, actual %0b", exp_bit.sdio, got.sdio);
                mismatch_count++;
            end
            if (got.fstart !== exp_bit.fstart)
            begin
                $error("frame_start: expected %0b, actual %0b", exp_bit.fstart, got.fstart);
                mismatch_count++;
            end
            if (got.fend !== exp_bit.fend)
            begin
                $error("frame_end: expected %0b, actual %0b", exp_bit.fend, got.fend);
                mismatch_count++;
            end
            if (got.upd !== exp_bit.upd)
            begin
                $error("io_update: expected %0b, actual %0b", exp_bit.upd, got.upd);
                mismatch_count++;
            end
            if (got.lst !== exp_bit.lst)
            begin
                $error("last: expected %0b, actual %0b", exp_bit.lst, got.lst);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [1:0]  channel = '0;
    logic [31:0] value = '0;
    logic [7:0]  raw_address = '0;
    logic [2:0]  raw_byte_count = '0;
    logic        raw_update = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        sdio_bit;
    logic        frame_start;
    logic        frame_end;
    logic        io_update;
    logic        last;

    frame_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    dds_spi_command_serializer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .channel        (channel),
        .value          (value),
        .raw_address    (raw_address),
        .raw_byte_count (raw_byte_count),
        .raw_update     (raw_update),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sdio_bit       (sdio_bit),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .io_update      (io_update),
        .last           (last)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: note accepted commands, check accepted bits, watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_command(opcode, channel, value, raw_address, raw_byte_count, raw_update);
            if (out_valid && out_ready)
                sb.check_bit('{sdio_bit, frame_start, frame_end, io_update, last});
        end
    end

    // drive one command beat; called and returns just after a falling edge
    task automatic send_command(logic [1:0] opc, logic [1:0] ch, logic [31:0] val,
                                logic [7:0] raddr, logic [2:0] rcount, logic rupd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        opcode         = opc;
        channel        = ch;
        value          = val;
        raw_address    = raddr;
        raw_byte_count = rcount;
        raw_update     = rupd;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // random command, values biased toward the saturation boundaries
    task automatic send_random();
        logic [1:0]  opc;
        logic [31:0] val;
        opc = 2'($urandom_range(3));
        case ($urandom_range(3))
            0: val = $urandom();
            1: val = $urandom_range(1100);
            2: val = $urandom_range(SYS_CLOCK_HZ + 10, SYS_CLOCK_HZ - 10);
            default: val = $urandom_range(SYS_CLOCK_HZ - 1);
        endcase
        send_command(opc, 2'($urandom_range(3)), val, 8'($urandom_range(255)),
                     3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    // wait at rising edges until every queued bit has arrived
    task automatic drain();
        in_valid = 1'b0;
        do
            @(posedge clk);
        while (sb.pending() > 0);
    endtask

    task automatic random_batch(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        @(negedge clk);
        repeat (count) send_random();
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: boundaries of every operation
        send_command(OPC_FREQ, 2'd0, 32'd0, 8'h00, 3'd0, 1'b0);
        send_command(OPC_FREQ, 2'd1, 32'd1, 8'hFF, 3'd7, 1'b1);
        send_command(OPC_FREQ, 2'd2, 32'(SYS_CLOCK_HZ - 1), 8'h00, 3'd0, 1'b0);
        send_command(OPC_FREQ, 2'd3, 32'(SYS_CLOCK_HZ), 8'h00, 3'd0, 1'b0);
        send_command(OPC_FREQ, 2'd3, 32'hFFFF_FFFF, 8'h00, 3'd0, 1'b0);
        send_command(OPC_PHASE, 2'd0, 32'd0, 8'h00, 3'd0, 1'b0);
        send_command(OPC_PHASE, 2'd1, 32'h0000_3FFF, 8'h00, 3'd0, 1'b0);
        send_command(OPC_PHASE, 2'd2, 32'h0000_4000, 8'h00, 3'd0, 1'b0);
        send_command(OPC_PHASE, 2'd3, 32'hFFFF_FFFF, 8'h00, 3'd0, 1'b0);
        send_command(OPC_AMP, 2'd0, 32'd0, 8'h00, 3'd0, 1'b0);
        send_command(OPC_AMP, 2'd1, 32'd1023, 8'h00, 3'd0, 1'b0);
        send_command(OPC_AMP, 2'd2, 32'd1024, 8'h00, 3'd0, 1'b0);
        send_command(OPC_AMP, 2'd3, 32'hFFFF_FFFF, 8'h00, 3'd0, 1'b0);
        // raw writes over every byte count, including zero and above four
        send_command(OPC_RAW, 2'd0, 32'hA5C3_5A3C, 8'h00, 3'd0, 1'b0);
        send_command(OPC_RAW, 2'd1, 32'hFFFF_FFFF, 8'hFF, 3'd1, 1'b1);
        send_command(OPC_RAW, 2'd2, 32'h1234_5678, 8'h81, 3'd2, 1'b0);
        send_command(OPC_RAW, 2'd3, 32'h8000_0001, 8'h7E, 3'd3, 1'b1);
        send_command(OPC_RAW, 2'd0, 32'hDEAD_BEEF, 8'h55, 3'd4, 1'b1);
        send_command(OPC_RAW, 2'd1, 32'hFFFF_FFFF, 8'hAA, 3'd5, 1'b0);
        send_command(OPC_RAW, 2'd2, 32'h0000_0000, 8'hFF, 3'd6, 1'b1);
        send_command(OPC_RAW, 2'd3, 32'hCAFE_F00D, 8'h00, 3'd7, 1'b0);
        drain();

        // random phases with different idling mixes
        random_batch(45, 0, 0);
        random_batch(45, 56, 0);
        random_batch(45, 0, 56);
        random_batch(45, 19, 19);

        // backpressure: long receiver hold-off while commands keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_left = HoldCycles;
            end
            begin
                @(negedge clk);
                repeat (20) send_random();
            end
        join
        drain();

        repeat (100) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
